[rtl/core/plist_pkg.sv]
// Package for the positional list core: sizes, opcodes, status codes,
// result kinds and the command/status structs between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package plist_pkg;

   // List capacity and derived widths.
   localparam int DEPTH    = 64;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);

   // Fixed transaction field widths.
   localparam int OP_W     = 2;
   localparam int SLOT_W   = 7;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;

   typedef logic [OP_W-1:0]     opcode_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [2:0]          res_kind_type;

   localparam opcode_type OP_DISPLAY = 2'd0;
   localparam opcode_type OP_INSERT  = 2'd1;
   localparam opcode_type OP_DELETE  = 2'd2;
   localparam opcode_type OP_SEARCH  = 2'd3;

   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_BADPOS   = 3'd1;
   localparam status_type ST_FULL     = 3'd2;
   localparam status_type ST_NOTFOUND = 3'd3;
   localparam status_type ST_EMPTY    = 3'd4;

   // Which kind of result the datapath builds when it loads the output register.
   localparam res_kind_type RES_BADPOS   = 3'd0;
   localparam res_kind_type RES_FULL     = 3'd1;
   localparam res_kind_type RES_INS_OK   = 3'd2;
   localparam res_kind_type RES_DEL_OK   = 3'd3;
   localparam res_kind_type RES_FOUND    = 3'd4;
   localparam res_kind_type RES_NOTFOUND = 3'd5;
   localparam res_kind_type RES_EMPTY    = 3'd6;
   localparam res_kind_type RES_DISP     = 3'd7;

   typedef struct packed {
      logic         take_req;   // capture the request and set up the index
      logic         ram_rd;     // read the list memory at the op's address
      logic         shift_wr;   // write read data one place over, step index
      logic         idx_inc;    // step the scan index
      logic         load_out;   // load the result register (commits ins/del)
      res_kind_type kind;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       pos_ok;       // slot valid for the captured insert/delete
      logic       full;
      logic       empty;
      logic       shift_more;   // another element must move
      logic       match;        // read data equals the search value
      logic       scan_last;    // index points at the final element
      logic       out_free;     // result register can take a new result
   } sts_type;

endpackage

[rtl/core/plist_req_if.sv]
// Request channel interface of the positional list core.
// Depends on plist_pkg for the field widths.
`timescale 1ns / 1ps

interface plist_req_if;
   logic                                valid;
   logic                                ready;
   logic [plist_pkg::OP_W-1:0]          opcode;
   logic [plist_pkg::SLOT_W-1:0]        slot;
   logic signed [plist_pkg::DATA_W-1:0] item_value;

   modport source (output valid, output opcode, output slot, output item_value,
                   input ready);
   modport sink   (input valid, input opcode, input slot, input item_value,
                   output ready);
endinterface

[rtl/core/plist_rsp_if.sv]
// Response channel interface of the positional list core.
// Depends on plist_pkg for the field widths.
`timescale 1ns / 1ps

interface plist_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [plist_pkg::STATUS_W-1:0]      status;
   logic [plist_pkg::SLOT_W-1:0]        found_slot;
   logic signed [plist_pkg::DATA_W-1:0] element;
   logic [plist_pkg::SLOT_W-1:0]        length;
   logic                                last;

   modport source (output valid, output status, output found_slot, output element,
                   output length, output last, input ready);
   modport sink   (input valid, input status, input found_slot, input element,
                   input length, input last, output ready);
endinterface

[rtl/core/plist_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module plist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // Read data holds until the next read.
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/core/plist_ctrl.sv]
// Controller state machine of the positional list core.
// Depends on plist_pkg; drives the datapath through cmd_type, watches sts_type.
`timescale 1ns / 1ps

module plist_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  plist_pkg::sts_type  sts,
   output plist_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DECIDE    = 3'd1;
   localparam logic [2:0] S_SHIFT_CHK = 3'd2;
   localparam logic [2:0] S_SHIFT_WR  = 3'd3;
   localparam logic [2:0] S_SCAN_RD   = 3'd4;
   localparam logic [2:0] S_SCAN_USE  = 3'd5;
   localparam logic [2:0] S_REPORT    = 3'd6;

   logic [2:0]              state_ff, state_in;
   plist_pkg::res_kind_type kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff <= kind_in;
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cmd          = '0;
      cmd.kind     = kind_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = S_DECIDE;
            end
         end
         S_DECIDE: begin
            unique case (sts.op)
               plist_pkg::OP_DISPLAY: begin
                  if (sts.empty) begin
                     kind_in  = plist_pkg::RES_EMPTY;
                     state_in = S_REPORT;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end
               plist_pkg::OP_INSERT: begin
                  if (!sts.pos_ok) begin
                     kind_in  = plist_pkg::RES_BADPOS;
                     state_in = S_REPORT;
                  end else if (sts.full) begin
                     kind_in  = plist_pkg::RES_FULL;
                     state_in = S_REPORT;
                  end else begin
                     state_in = S_SHIFT_CHK;
                  end
               end
               plist_pkg::OP_DELETE: begin
                  if (!sts.pos_ok) begin
                     kind_in  = plist_pkg::RES_BADPOS;
                     state_in = S_REPORT;
                  end else begin
                     state_in = S_SHIFT_CHK;
                  end
               end
               plist_pkg::OP_SEARCH: begin
                  if (sts.empty) begin
                     kind_in  = plist_pkg::RES_NOTFOUND;
                     state_in = S_REPORT;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end
            endcase
         end
         S_SHIFT_CHK: begin
            if (sts.shift_more) begin
               cmd.ram_rd = 1'b1;
               state_in   = S_SHIFT_WR;
            end else begin
               kind_in  = (sts.op == plist_pkg::OP_INSERT) ? plist_pkg::RES_INS_OK
                                                           : plist_pkg::RES_DEL_OK;
               state_in = S_REPORT;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SHIFT_CHK;
         end
         S_SCAN_RD: begin
            cmd.ram_rd = 1'b1;
            state_in   = S_SCAN_USE;
         end
         S_SCAN_USE: begin
            if (sts.op == plist_pkg::OP_DISPLAY) begin
               if (sts.out_free) begin
                  cmd.load_out = 1'b1;
                  cmd.kind     = plist_pkg::RES_DISP;
                  cmd.idx_inc  = 1'b1;
                  state_in     = sts.scan_last ? S_IDLE : S_SCAN_RD;
               end
            end else if (sts.match) begin
               kind_in  = plist_pkg::RES_FOUND;
               state_in = S_REPORT;
            end else if (sts.scan_last) begin
               kind_in  = plist_pkg::RES_NOTFOUND;
               state_in = S_REPORT;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end
         end
         S_REPORT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[rtl/core/plist_dpath.sv]
// Datapath of the positional list core: request registers, count, index,
// list memory and the result register. Depends on plist_pkg and plist_ram.
`timescale 1ns / 1ps

module plist_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [plist_pkg::OP_W-1:0]          req_opcode,
   input  logic [plist_pkg::SLOT_W-1:0]        req_slot,
   input  logic signed [plist_pkg::DATA_W-1:0] req_item_value,
   input  plist_pkg::cmd_type                  cmd,
   output plist_pkg::sts_type                  sts,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [plist_pkg::STATUS_W-1:0]      rsp_status,
   output logic [plist_pkg::SLOT_W-1:0]        rsp_found_slot,
   output logic signed [plist_pkg::DATA_W-1:0] rsp_element,
   output logic [plist_pkg::SLOT_W-1:0]        rsp_length,
   output logic                                rsp_last
);

   localparam int IW = plist_pkg::IDX_W;
   localparam int CW = plist_pkg::CNT_W;
   localparam int SW = plist_pkg::SLOT_W;
   localparam int DW = plist_pkg::DATA_W;

   plist_pkg::opcode_type op_ff;
   logic [SW-1:0]         slot_ff;
   logic [DW-1:0]         value_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [plist_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SW-1:0]         rsp_found_ff, rsp_found_in;
   logic [DW-1:0]         rsp_elem_ff, rsp_elem_in;
   logic [SW-1:0]         rsp_length_ff, rsp_length_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [CW-1:0]         idx_up, idx_dn;
   logic [SW-1:0]         slot_dec, req_slot_dec;
   logic [SW:0]           cnt_p1;
   logic                  is_insert, commit_ins, commit_del;

   logic                  wr_en;
   logic [IW-1:0]         wr_addr, rd_addr;
   logic [DW-1:0]         wr_data, rd_data;

   assign idx_up       = idx_ff + CW'(1);
   assign idx_dn       = idx_ff - CW'(1);
   assign slot_dec     = slot_ff - SW'(1);
   assign req_slot_dec = req_slot - SW'(1);
   assign cnt_p1       = (SW + 1)'(count_ff) + (SW + 1)'(1);
   assign is_insert    = (op_ff == plist_pkg::OP_INSERT);
   assign commit_ins   = cmd.load_out && (cmd.kind == plist_pkg::RES_INS_OK);
   assign commit_del   = cmd.load_out && (cmd.kind == plist_pkg::RES_DEL_OK);

   // Status toward the controller.
   always_comb begin
      sts.op = op_ff;
      if (op_ff == plist_pkg::OP_INSERT) begin
         sts.pos_ok = (slot_ff != '0) && ({1'b0, slot_ff} <= cnt_p1);
      end else begin
         sts.pos_ok = (slot_ff != '0) && (slot_ff <= SW'(count_ff));
      end
      sts.full       = (count_ff == CW'(plist_pkg::DEPTH));
      sts.empty      = (count_ff == '0);
      sts.shift_more = is_insert ? (SW'(idx_ff) >= slot_ff) : (idx_up < count_ff);
      sts.match      = (rd_data == value_ff);
      sts.scan_last  = (idx_up == count_ff);
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // Memory addressing: an insert moves element i-1 to i, a delete i+1 to i.
   always_comb begin
      if (op_ff == plist_pkg::OP_INSERT) begin
         rd_addr = idx_dn[IW-1:0];
      end else if (op_ff == plist_pkg::OP_DELETE) begin
         rd_addr = idx_up[IW-1:0];
      end else begin
         rd_addr = idx_ff[IW-1:0];
      end
      wr_en = cmd.shift_wr || commit_ins;
      if (cmd.shift_wr) begin
         wr_addr = idx_ff[IW-1:0];
         wr_data = rd_data;
      end else begin
         wr_addr = slot_dec[IW-1:0];
         wr_data = value_ff;
      end
   end

   plist_ram #(
      .WIDTH (DW),
      .DEPTH (plist_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.ram_rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Index and count.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.take_req) begin
         if (req_opcode == plist_pkg::OP_INSERT) begin
            idx_in = count_ff;
         end else if (req_opcode == plist_pkg::OP_DELETE) begin
            idx_in = CW'(req_slot_dec);
         end else begin
            idx_in = '0;
         end
      end else if (cmd.shift_wr) begin
         idx_in = is_insert ? idx_dn : idx_up;
      end else if (cmd.idx_inc) begin
         idx_in = idx_up;
      end

      count_in = count_ff;
      if (commit_ins) begin
         count_in = count_ff + CW'(1);
      end else if (commit_del) begin
         count_in = count_ff - CW'(1);
      end
   end

   // Result register contents.
   always_comb begin
      rsp_status_in = plist_pkg::ST_OK;
      rsp_found_in  = '0;
      rsp_elem_in   = '0;
      rsp_last_in   = 1'b1;
      rsp_length_in = SW'(count_in);
      unique case (cmd.kind)
         plist_pkg::RES_BADPOS:   rsp_status_in = plist_pkg::ST_BADPOS;
         plist_pkg::RES_FULL:     rsp_status_in = plist_pkg::ST_FULL;
         plist_pkg::RES_INS_OK: begin
            rsp_found_in = slot_ff;
            rsp_elem_in  = value_ff;
         end
         plist_pkg::RES_DEL_OK:   rsp_status_in = plist_pkg::ST_OK;
         plist_pkg::RES_FOUND: begin
            rsp_found_in = SW'(idx_up);
            rsp_elem_in  = value_ff;
         end
         plist_pkg::RES_NOTFOUND: rsp_status_in = plist_pkg::ST_NOTFOUND;
         plist_pkg::RES_EMPTY:    rsp_status_in = plist_pkg::ST_EMPTY;
         plist_pkg::RES_DISP: begin
            rsp_found_in = SW'(idx_up);
            rsp_elem_in  = rd_data;
            rsp_last_in  = (idx_up == count_ff);
         end
         default:                 rsp_status_in = plist_pkg::ST_OK;
      endcase

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      if (cmd.take_req) begin
         op_ff    <= req_opcode;
         slot_ff  <= req_slot;
         value_ff <= req_item_value;
      end
      if (cmd.load_out) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_elem_ff   <= rsp_elem_in;
         rsp_length_ff <= rsp_length_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found_slot = rsp_found_ff;
   assign rsp_element    = rsp_elem_ff;
   assign rsp_length     = rsp_length_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

[rtl/core/positional_list_insert_delete_search_core.sv]
// Positional list core, top level: joins controller and datapath to the
// request and response channels. Depends on plist_pkg, the channel
// interfaces, plist_ctrl, plist_dpath and plist_ram.
`timescale 1ns / 1ps

// The core keeps an ordered list of up to plist_pkg::DEPTH signed 32-bit
// values in a RAM with one write port and one registered read port, so each
// element it touches is read in one state and its data used or written in a
// second. A request transaction is accepted only while the controller is
// idle, so operations never overlap. A request rejected for a bad position or
// a full list, and a display or search of an empty list, go straight from the
// decision to the report. A waiting response that is not taken holds the
// controller when it has a result to load. A finished response sits in an
// output register, so a new request transaction is accepted while the last
// response still waits to be taken. Each request yields exactly one response,
// except a display of a non-empty list, which yields one per element with
// last set on the final one. The list comes out of reset empty; the memory
// needs no clearing pass because only entries below the count are ever read.

module positional_list_insert_delete_search_core (
   input  logic        clock,
   input  logic        reset,
   plist_req_if.sink   req,
   plist_rsp_if.source rsp
);

   plist_pkg::cmd_type cmd;
   plist_pkg::sts_type sts;

   // The controller sequences each operation; it sees the datapath only
   // through the status struct and steers it only through the command struct.
   plist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the captured request, the element count, the walk
   // index, the list memory and the response register.
   plist_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_opcode     (req.opcode),
      .req_slot       (req.slot),
      .req_item_value (req.item_value),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_ready      (rsp.ready),
      .rsp_valid      (rsp.valid),
      .rsp_status     (rsp.status),
      .rsp_found_slot (rsp.found_slot),
      .rsp_element    (rsp.element),
      .rsp_length     (rsp.length),
      .rsp_last       (rsp.last)
   );

`ifndef SYNTHESIS
   // A new response must never overwrite one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_out && rsp.valid && !rsp.ready))
      else $error("response register overwritten while stalled");

   // One request at a time: after a request transaction the core is busy.
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request accepted while previous one is in progress");

   // The reported length never exceeds the list capacity.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.length <= plist_pkg::SLOT_W'(plist_pkg::DEPTH)))
      else $error("list length beyond capacity");

   // A successful insert reports the slot it wrote, which is never zero.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && (cmd.kind == plist_pkg::RES_INS_OK))
         |=> (rsp.found_slot != '0))
      else $error("insert reported without a position");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for the positional list core: directed and random
// display, insert, delete and search transactions checked by a scoreboard class.
// Depends on plist_pkg, plist_req_if, plist_rsp_if and the core top level.
`timescale 1ns / 1ps

module testbench;

   localparam int DEPTH  = plist_pkg::DEPTH;
   localparam int SLOT_W = plist_pkg::SLOT_W;
   localparam int DATA_W = plist_pkg::DATA_W;

   // One expected response transaction, at the widths of the response channel.
   typedef struct {
      plist_pkg::status_type status;
      logic [SLOT_W-1:0]     found_slot;
      logic [DATA_W-1:0]     element;
      logic [SLOT_W-1:0]     length;
      logic                  last;
   } list_result_type;

   // The scoreboard keeps its own copy of the list. Each accepted request is
   // worked through that copy, and the responses it must cause are queued in order.
   class list_scoreboard;
      logic [DATA_W-1:0] store [DEPTH];
      int                count;
      list_result_type   pending_results [$];
      int                errors;
      int                full_rejects;
      int                max_count;

      function new();
         count        = 0;
         errors       = 0;
         full_rejects = 0;
         max_count    = 0;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function void queue_result(plist_pkg::status_type st, int slot_no,
                                 logic [DATA_W-1:0] value, logic fin);
         list_result_type r;
         r.status     = st;
         r.found_slot = SLOT_W'(slot_no);
         r.element    = value;
         r.length     = SLOT_W'(count);
         r.last       = fin;
         pending_results.push_back(r);
      endfunction

      // Apply one accepted request to the list copy and queue its responses.
      function void note_request(plist_pkg::opcode_type op, logic [SLOT_W-1:0] slot,
                                 logic [DATA_W-1:0] value);
         int i;
         int s;
         bit hit;
         s   = int'(slot);
         hit = 1'b0;
         case (op)
            plist_pkg::OP_DISPLAY: begin
               if (count == 0) begin
                  queue_result(plist_pkg::ST_EMPTY, 0, '0, 1'b1);
               end else begin
                  for (i = 0; i < count; i++)
                     queue_result(plist_pkg::ST_OK, i + 1, store[i], i == count - 1);
               end
            end
            plist_pkg::OP_INSERT: begin
               if (s < 1 || s > count + 1) begin
                  queue_result(plist_pkg::ST_BADPOS, 0, '0, 1'b1);
               end else if (count >= DEPTH) begin
                  full_rejects++;
                  queue_result(plist_pkg::ST_FULL, 0, '0, 1'b1);
               end else begin
                  for (i = count; i > s - 1; i--)
                     store[i] = store[i - 1];
                  store[s - 1] = value;
                  count++;
                  if (count > max_count) max_count = count;
                  queue_result(plist_pkg::ST_OK, s, value, 1'b1);
               end
            end
            plist_pkg::OP_DELETE: begin
               if (s < 1 || s > count) begin
                  queue_result(plist_pkg::ST_BADPOS, 0, '0, 1'b1);
               end else begin
                  for (i = s - 1; i + 1 < count; i++)
                     store[i] = store[i + 1];
                  count--;
                  queue_result(plist_pkg::ST_OK, 0, '0, 1'b1);
               end
            end
            default: begin
               for (i = 0; i < count && !hit; i++) begin
                  if (store[i] == value) begin
                     hit = 1'b1;
                     queue_result(plist_pkg::ST_OK, i + 1, value, 1'b1);
                  end
               end
               if (!hit) queue_result(plist_pkg::ST_NOTFOUND, 0, '0, 1'b1);
            end
         endcase
      endfunction

      task report_mismatch(string what);
         if (errors < 40) $display("MISMATCH at %0t ns: %s", $time, what);
         errors++;
      endtask

      task compare_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, wanted 0x%0h", name, got, want));
      endtask

      // Compare one accepted response with the oldest expectation.
      task check_response(plist_pkg::status_type st, logic [SLOT_W-1:0] fslot,
                          logic [DATA_W-1:0] elem, logic [SLOT_W-1:0] len, logic fin);
         list_result_type w;
         if (pending_results.size() == 0) begin
            report_mismatch("response transaction with no expectation waiting");
         end else begin
            w = pending_results.pop_front();
            compare_field("status", DATA_W'(st), DATA_W'(w.status));
            compare_field("found_slot", DATA_W'(fslot), DATA_W'(w.found_slot));
            compare_field("element", elem, w.element);
            compare_field("length", DATA_W'(len), DATA_W'(w.length));
            compare_field("last", DATA_W'(fin), DATA_W'(w.last));
         end
      endtask
   endclass

   localparam int HALF_PERIOD  = 4;
   localparam int IDLE_LIMIT   = 3000;   // cycles with no transaction before giving up
   localparam int LONG_HOLD    = 150;    // receiver hold-off used to back up the core
   localparam int DRAIN_CYCLES = 16;

   logic clock = 1'b0;
   logic reset;

   plist_req_if req_ch ();
   plist_rsp_if rsp_ch ();

   positional_list_insert_delete_search_core u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   list_scoreboard sb;

   // Flags from the stimulus thread to the receiver process.
   bit quiet_phase;       // no idling on either side
   bit long_hold_req;     // ask the receiver for one long hold-off
   int req_count = 0;
   int rsp_count = 0;
   int op_count [4];
   int idle_cycles = 0;

   always #(HALF_PERIOD) clock = ~clock;

   // Drive one request at the falling edge and hold it until the core takes it.
   // The scoreboard learns of it at the very edge where the handshake happens.
   task automatic send_request(plist_pkg::opcode_type op, logic [SLOT_W-1:0] slot,
                               logic [DATA_W-1:0] value);
      @(negedge clock);
      req_ch.valid      <= 1'b1;
      req_ch.opcode     <= op;
      req_ch.slot       <= slot;
      req_ch.item_value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(op, slot, value);
      req_count++;
      op_count[op]++;
   endtask

   // Drop valid for a number of cycles; the payload gets fresh noise meanwhile.
   task automatic sender_idle(int n);
      repeat (n) begin
         @(negedge clock);
         req_ch.valid      <= 1'b0;
         req_ch.slot       <= SLOT_W'($urandom);
         req_ch.item_value <= $urandom;
      end
   endtask

   // Values: mostly full-range random, with a small pool so that duplicates
   // occur and the search has to find the first of several matches.
   function automatic logic [DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return DATA_W'($urandom_range(0, 4) - 2);
      if (r < 23) return 32'h8000_0000;
      if (r < 26) return 32'h7FFF_FFFF;
      return $urandom;
   endfunction

   // One random request. Most of them use a position that is valid for the
   // current list; the rest pick any slot the field allows.
   task automatic random_item();
      plist_pkg::opcode_type op;
      logic [SLOT_W-1:0]     slot;
      logic [DATA_W-1:0]     value;
      int                    r;
      int                    ins_weight;
      r = $urandom_range(0, 99);
      // Lean toward deletes when the list gets long, toward inserts when short.
      ins_weight = (sb.count > 40) ? 25 : (sb.count < 8 ? 55 : 40);
      if (r < 8)                            op = plist_pkg::OP_DISPLAY;
      else if (r < 8 + ins_weight)          op = plist_pkg::OP_INSERT;
      else if (r < 8 + ins_weight + 30)     op = plist_pkg::OP_DELETE;
      else                                  op = plist_pkg::OP_SEARCH;
      value = pick_value();
      if ($urandom_range(0, 99) < 15) begin
         slot = SLOT_W'($urandom_range(0, 127));
      end else if (op == plist_pkg::OP_INSERT) begin
         slot = SLOT_W'($urandom_range(1, sb.count + 1));
      end else if (sb.count > 0) begin
         slot = SLOT_W'($urandom_range(1, sb.count));
      end else begin
         slot = SLOT_W'($urandom_range(0, 127));
      end
      // A search mostly looks for a value that is really in the list.
      if (op == plist_pkg::OP_SEARCH && sb.count > 0 && $urandom_range(0, 99) < 65)
         value = sb.store[$urandom_range(0, sb.count - 1)];
      if (!quiet_phase && $urandom_range(0, 3) == 0)
         sender_idle($urandom_range(1, 3));
      send_request(op, slot, value);
   endtask

   // Receiver: ready changes at the falling edge only. It idles in short random
   // bursts, once holds off for a long stretch, and never idles in the quiet phase.
   initial begin : receiver
      int hold_left;
      int burst_left;
      bit hold_done;
      hold_left    = 0;
      burst_left   = 0;
      hold_done    = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (quiet_phase) begin
            rsp_ch.ready <= 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_ch.ready <= 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(1, 3) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Every response transaction is checked at the rising edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_response(rsp_ch.status, rsp_ch.found_slot, rsp_ch.element,
                           rsp_ch.length, rsp_ch.last);
         rsp_count++;
      end
   end

   // Watchdog: a long run of cycles without any transaction on either channel
   // means the core has hung or stopped answering.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles, %0d responses outstanding",
                  IDLE_LIMIT, sb.pending());
         $display("FAIL positional_list_insert_delete_search_core");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int i;
      int k;
      // Every input of the core is known from time zero.
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.opcode     = plist_pkg::OP_DISPLAY;
      req_ch.slot       = '0;
      req_ch.item_value = '0;
      quiet_phase       = 1'b0;
      long_hold_req     = 1'b0;
      sb                = new();

      // Synchronous reset, released at a falling edge.
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: operations on the empty list first.
      send_request(plist_pkg::OP_DISPLAY, 7'd0, 32'd0);         // display of an empty list
      send_request(plist_pkg::OP_DELETE, 7'd1, 32'd0);          // delete from an empty list
      send_request(plist_pkg::OP_SEARCH, 7'd0, 32'h0000_0000);  // search of an empty list
      send_request(plist_pkg::OP_INSERT, 7'd0, 32'h1234_5678);  // slot zero is never valid
      send_request(plist_pkg::OP_INSERT, 7'd2, 32'h1234_5678);  // one past count + 1
      // Build a short list through the front, the end and the middle.
      send_request(plist_pkg::OP_INSERT, 7'd1, 32'h7FFF_FFFF);
      send_request(plist_pkg::OP_INSERT, 7'd1, 32'h8000_0000);
      send_request(plist_pkg::OP_INSERT, 7'd3, 32'hFFFF_FFFF);
      send_request(plist_pkg::OP_INSERT, 7'd2, 32'h0000_0000);
      send_request(plist_pkg::OP_INSERT, 7'd127, 32'hA5A5_A5A5); // all slot bits set
      send_request(plist_pkg::OP_DISPLAY, 7'd127, 32'hFFFF_FFFF);
      send_request(plist_pkg::OP_SEARCH, 7'd0, 32'h8000_0000);  // hit at the first position
      send_request(plist_pkg::OP_SEARCH, 7'd0, 32'hFFFF_FFFF);  // hit at the last position
      send_request(plist_pkg::OP_SEARCH, 7'd0, 32'h0001_2345);  // miss on a non-empty list
      send_request(plist_pkg::OP_INSERT, 7'd2, 32'h0000_0000);  // duplicate of element two
      send_request(plist_pkg::OP_SEARCH, 7'd5, 32'h0000_0000);  // the first of two matches
      send_request(plist_pkg::OP_DELETE, 7'd0, 32'd0);          // slot zero
      send_request(plist_pkg::OP_DELETE, 7'd6, 32'd0);          // one past the count
      send_request(plist_pkg::OP_DELETE, 7'd5, 32'd0);          // the last element
      send_request(plist_pkg::OP_DELETE, 7'd1, 32'd0);          // the first element
      send_request(plist_pkg::OP_DISPLAY, 7'd0, 32'd0);

      // Random part with idling on both sides. Partway through, the receiver
      // holds off for a long stretch while requests keep coming, so the output
      // register fills and the core must stall its request channel.
      for (i = 0; i < 220; i++) begin
         if (i == 90) long_hold_req = 1'b1;
         random_item();
      end

      // Fill the list to capacity with random positions and contents.
      while (sb.count < DEPTH) begin
         if ($urandom_range(0, 4) == 0) sender_idle($urandom_range(1, 3));
         send_request(plist_pkg::OP_INSERT, SLOT_W'($urandom_range(1, sb.count + 1)),
                      pick_value());
      end
      // A full list: a valid position reports the list as full, while a bad
      // position is still reported as a bad position, since that is checked first.
      send_request(plist_pkg::OP_INSERT, SLOT_W'($urandom_range(1, DEPTH)), $urandom);
      send_request(plist_pkg::OP_INSERT, SLOT_W'(DEPTH + 1), $urandom);
      send_request(plist_pkg::OP_INSERT, SLOT_W'(DEPTH + 2), $urandom);
      send_request(plist_pkg::OP_INSERT, 7'd127, $urandom);
      send_request(plist_pkg::OP_DISPLAY, 7'd0, 32'd0);
      send_request(plist_pkg::OP_SEARCH, 7'd0, sb.store[DEPTH - 1]);
      send_request(plist_pkg::OP_DELETE, SLOT_W'(DEPTH + 1), 32'd0);
      send_request(plist_pkg::OP_DELETE, SLOT_W'(DEPTH), 32'd0);
      send_request(plist_pkg::OP_INSERT, SLOT_W'(DEPTH), 32'h8000_0000);
      send_request(plist_pkg::OP_DISPLAY, 7'd0, 32'd0);

      // Last part: no idling on either side, back-to-back transactions.
      quiet_phase = 1'b1;
      for (k = 0; k < 60; k++)
         random_item();

      @(negedge clock);
      req_ch.valid <= 1'b0;

      // Let every expected response arrive, then keep the clock running so that
      // any response that should not be there still shows.
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests (display %0d, insert %0d, delete %0d, search %0d).",
               req_count, op_count[plist_pkg::OP_DISPLAY], op_count[plist_pkg::OP_INSERT],
               op_count[plist_pkg::OP_DELETE], op_count[plist_pkg::OP_SEARCH]);
      $display("Checked %0d responses; list grew to %0d entries, %0d inserts hit a full list.",
               rsp_count, sb.max_count, sb.full_rejects);
      if (sb.errors == 0) begin
         $display("PASS positional_list_insert_delete_search_core");
      end else begin
         $display("%0d mismatches found", sb.errors);
         $display("FAIL positional_list_insert_delete_search_core");
      end
      $finish;
   end

endmodule
